@@ rtl/core/srmm_pkg.sv @@
// Shared types, codes and default sizes for the sparse row matrix multiply unit.
package srmm_pkg;

  localparam int unsigned INNER_DIM_DEF      = 64;
  localparam int unsigned OUT_COLS_DEF       = 64;
  localparam int unsigned B_NNZ_CAPACITY_DEF = 1024;

  localparam int unsigned ACC_W  = 56;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned FRAC_W = 16;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_A      = 2'd1,
    FUNC_FINISH = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DROP = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  // One classified command waiting between front and back.
  typedef struct packed {
    func_e                    op;
    logic                     bad;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [VAL_W-1:0]  value;
  } cmd_t;

endpackage

@@ rtl/core/srmm_in_if.sv @@
// Command channel: valid/ready handshake with one command word.
interface srmm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [5:0]         row_index;
  logic [5:0]         col_index;
  logic signed [31:0] value;

  modport source (output valid, func, row_index, col_index, value, input ready);
  modport sink   (input valid, func, row_index, col_index, value, output ready);
endinterface

@@ rtl/core/srmm_out_if.sv @@
// Result channel: valid/ready handshake with one result word.
interface srmm_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         out_column;
  logic signed [31:0] out_value;
  logic               last;
  logic [1:0]         status;

  modport source (output valid, out_column, out_value, last, status, input ready);
  modport sink   (input valid, out_column, out_value, last, status, output ready);
endinterface

@@ rtl/core/srmm_front.sv @@
// Front end: accepts command words, checks ranges and queues them for the back end.
module srmm_front
  import srmm_pkg::*;
#(
  parameter int unsigned INNER_DIM = INNER_DIM_DEF,
  parameter int unsigned OUT_COLS  = OUT_COLS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  srmm_in_if.sink req_i,
  input  logic  busy_init_i,
  output logic  cmd_valid_o,
  output cmd_t  cmd_o,
  input  logic  cmd_pop_i
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  cmd_t       in_cmd;

  // Hold off new words during the reset clearing pass or when the queue is full
  assign req_i.ready = (cnt_q != 2'd2) && !busy_init_i;
  assign push        = req_i.valid && req_i.ready;

  // Classify the incoming word
  always_comb begin
    in_cmd.op    = func_e'(req_i.func);
    in_cmd.row   = req_i.row_index;
    in_cmd.col   = req_i.col_index;
    in_cmd.value = req_i.value;
    unique case (func_e'(req_i.func))
      FUNC_LOAD: in_cmd.bad = (32'(req_i.row_index) >= 32'(INNER_DIM)) ||
                              (32'(req_i.col_index) >= 32'(OUT_COLS));
      FUNC_A:    in_cmd.bad = (32'(req_i.col_index) >= 32'(INNER_DIM));
      default:   in_cmd.bad = 1'b0;
    endcase
  end

  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ cmd_pop_i;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the queued word
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

@@ rtl/core/srmm_back.sv @@
// Back end: B store, row walk with multiply-accumulate, row emit and acknowledgements.
module srmm_back
  import srmm_pkg::*;
#(
  parameter int unsigned INNER_DIM      = INNER_DIM_DEF,
  parameter int unsigned OUT_COLS       = OUT_COLS_DEF,
  parameter int unsigned B_NNZ_CAPACITY = B_NNZ_CAPACITY_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic  cmd_valid_i,
  input  cmd_t  cmd_i,
  output logic  cmd_pop_o,
  output logic  busy_init_o,
  srmm_out_if.source rsp_o
);

  localparam int unsigned IDW = (INNER_DIM > 1) ? $clog2(INNER_DIM) : 1;
  localparam int unsigned RW  = (IDW > IDX_W) ? IDW : IDX_W;
  localparam int unsigned AW  = $clog2(B_NNZ_CAPACITY);
  localparam int unsigned CW  = $clog2(B_NNZ_CAPACITY + 1);
  localparam int unsigned OCW = $clog2(OUT_COLS);
  localparam int unsigned QW  = PROD_W - FRAC_W;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ROW   = 4'd2;
  localparam logic [3:0] S_LOAD  = 4'd3;
  localparam logic [3:0] S_WRD   = 4'd4;
  localparam logic [3:0] S_WMUL  = 4'd5;
  localparam logic [3:0] S_WACC  = 4'd6;
  localparam logic [3:0] S_WADD  = 4'd7;
  localparam logic [3:0] S_ACK   = 4'd8;
  localparam logic [3:0] S_FRD   = 4'd9;
  localparam logic [3:0] S_FEMIT = 4'd10;
  localparam logic [3:0] S_CLR   = 4'd11;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Control and datapath registers
  logic [3:0]                state_q, state_d;
  cmd_t                      cur_q, cur_d;
  logic [AW-1:0]             addr_q, addr_d;
  logic [CW-1:0]             left_q, left_d;
  logic [OCW-1:0]            col_q, col_d;
  logic [IDW-1:0]            ptr_q, ptr_d;
  logic [CW-1:0]             stored_q, stored_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic [OUT_COLS-1:0]       accv_q, accv_d;
  logic                      ov_q, ov_d;
  logic [IDX_W-1:0]          ocol_q, ocol_d;
  logic signed [VAL_W-1:0]   oval_q, oval_d;
  logic                      olast_q, olast_d;
  status_e                   ost_q, ost_d;

  // Memories and their ports
  logic [AW+CW-1:0]          row_mem [INNER_DIM];
  logic [AW+CW-1:0]          row_rd_q;
  logic                      row_we, row_re;
  logic [IDW-1:0]            row_wa, row_ra;
  logic [AW+CW-1:0]          row_wd;

  logic signed [VAL_W-1:0]   bval_mem [B_NNZ_CAPACITY];
  logic [OCW-1:0]            bcol_mem [B_NNZ_CAPACITY];
  logic signed [VAL_W-1:0]   bval_q;
  logic [OCW-1:0]            bcol_q;
  logic                      b_we, b_re;

  logic signed [ACC_W-1:0]   acc_mem [OUT_COLS];
  logic signed [ACC_W-1:0]   acc_rd_q;
  logic                      acc_we, acc_re;
  logic signed [ACC_W-1:0]   acc_wd;

  // Helpers
  logic [RW-1:0]             row_ext, col_ext;
  logic [AW-1:0]             row_first;
  logic [CW-1:0]             row_cnt;
  logic                      out_free, full;
  logic signed [QW-1:0]      q;
  logic signed [ACC_W-1:0]   acc_cur;
  logic signed [ACC_W:0]     sum;
  logic                      sat32;

  assign row_ext   = RW'(cmd_i.row);
  assign col_ext   = RW'(cmd_i.col);
  assign row_first = row_rd_q[AW+CW-1:CW];
  assign row_cnt   = row_rd_q[CW-1:0];
  assign out_free  = !ov_q || rsp_o.ready;
  assign full      = (stored_q >= CW'(B_NNZ_CAPACITY));
  assign q         = prod_q[PROD_W-1:FRAC_W];
  assign acc_cur   = accv_q[col_q] ? acc_rd_q : '0;
  assign sum       = {acc_cur[ACC_W-1], acc_cur} + (ACC_W+1)'(q);
  assign sat32     = !((&acc_cur[ACC_W-1:VAL_W-1]) || !(|acc_cur[ACC_W-1:VAL_W-1]));

  assign busy_init_o = (state_q == S_INIT);

  assign rsp_o.valid      = ov_q;
  assign rsp_o.out_column = ocol_q;
  assign rsp_o.out_value  = oval_q;
  assign rsp_o.last       = olast_q;
  assign rsp_o.status     = ost_q;

  // Sequence one command at a time
  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    addr_d   = addr_q;
    left_d   = left_q;
    col_d    = col_q;
    ptr_d    = ptr_q;
    stored_d = stored_q;
    prod_d   = prod_q;
    accv_d   = accv_q;
    ov_d     = ov_q && !rsp_o.ready;
    ocol_d   = ocol_q;
    oval_d   = oval_q;
    olast_d  = olast_q;
    ost_d    = ost_q;
    cmd_pop_o = 1'b0;
    row_we   = 1'b0;
    row_wa   = ptr_q;
    row_wd   = '0;
    row_re   = 1'b0;
    row_ra   = row_ext[IDW-1:0];
    b_we     = 1'b0;
    b_re     = 1'b0;
    acc_we   = 1'b0;
    acc_re   = 1'b0;
    acc_wd   = sum[ACC_W-1:0];

    unique case (state_q)
      S_INIT, S_CLR: begin
        // Sweep the row table to zero counts
        row_we = 1'b1;
        ptr_d  = ptr_q + 1'b1;
        if (ptr_q == IDW'(INNER_DIM - 1)) begin
          ptr_d    = '0;
          stored_d = '0;
          state_d  = (state_q == S_INIT) ? S_IDLE : S_ACK;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          unique case (cmd_i.op)
            FUNC_LOAD: begin
              row_re  = 1'b1;
              state_d = S_ROW;
            end
            FUNC_A: begin
              row_re  = 1'b1;
              row_ra  = col_ext[IDW-1:0];
              state_d = cmd_i.bad ? S_ACK : S_ROW;
            end
            FUNC_FINISH: begin
              col_d   = '0;
              state_d = S_FRD;
            end
            FUNC_CLEAR: begin
              ptr_d   = '0;
              state_d = S_CLR;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_ROW: begin
        if (cur_q.op == FUNC_LOAD) begin
          state_d = S_LOAD;
        end else begin
          addr_d  = row_first;
          left_d  = row_cnt;
          state_d = (row_cnt == '0) ? S_ACK : S_WRD;
        end
      end
      S_LOAD: begin
        // Append the entry to the store, or drop it if bad or the store is full, and acknowledge
        if (out_free) begin
          ov_d    = 1'b1;
          ocol_d  = '0;
          oval_d  = '0;
          olast_d = 1'b1;
          ost_d   = ST_OK;
          if (cur_q.bad || full) begin
            ost_d = ST_DROP;
          end else begin
            b_we     = 1'b1;
            row_we   = 1'b1;
            row_wa   = RW'(cur_q.row) >= RW'(0) ? IDW'(RW'(cur_q.row)) : '0;
            row_wd   = {(row_cnt == '0) ? stored_q[AW-1:0] : row_first, row_cnt + 1'b1};
            stored_d = stored_q + 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      S_WRD: begin
        b_re    = 1'b1;
        state_d = S_WMUL;
      end
      S_WMUL: begin
        prod_d  = cur_q.value * bval_q;
        col_d   = bcol_q;
        state_d = S_WACC;
      end
      S_WACC: begin
        acc_re  = 1'b1;
        state_d = S_WADD;
      end
      S_WADD: begin
        // Saturate the running sum and write it back
        if (sum[ACC_W] != sum[ACC_W-1]) begin
          acc_wd = sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        acc_we        = 1'b1;
        accv_d[col_q] = 1'b1;
        addr_d        = addr_q + 1'b1;
        left_d        = left_q - 1'b1;
        state_d       = (left_q == CW'(1)) ? S_ACK : S_WRD;
      end
      S_ACK: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ocol_d  = '0;
          oval_d  = '0;
          olast_d = 1'b1;
          ost_d   = ST_OK;
          state_d = S_IDLE;
        end
      end
      S_FRD: begin
        acc_re  = 1'b1;
        state_d = S_FEMIT;
      end
      S_FEMIT: begin
        // Emit one column, clamped to 32 bits, and drop its sum
        if (out_free) begin
          ov_d    = 1'b1;
          ocol_d  = IDX_W'(col_q);
          olast_d = (col_q == OCW'(OUT_COLS - 1));
          if (sat32) begin
            oval_d = acc_cur[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
            ost_d  = ST_SAT;
          end else begin
            oval_d = acc_cur[VAL_W-1:0];
            ost_d  = ST_OK;
          end
          accv_d[col_q] = 1'b0;
          col_d         = col_q + 1'b1;
          state_d       = (col_q == OCW'(OUT_COLS - 1)) ? S_IDLE : S_FRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      ptr_q    <= '0;
      stored_q <= '0;
      accv_q   <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      stored_q <= stored_d;
      accv_q   <= accv_d;
      ov_q     <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    addr_q  <= addr_d;
    left_q  <= left_d;
    col_q   <= col_d;
    prod_q  <= prod_d;
    ocol_q  <= ocol_d;
    oval_q  <= oval_d;
    olast_q <= olast_d;
    ost_q   <= ost_d;
  end

  // Row table: first slot and count per row of B
  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    if (row_re) begin
      row_rd_q <= row_mem[row_ra];
    end
  end

  // B entry store
  always_ff @(posedge clk_i) begin
    if (b_we) begin
      bval_mem[stored_q[AW-1:0]] <= cur_q.value;
      bcol_mem[stored_q[AW-1:0]] <= OCW'(cur_q.col);
    end
    if (b_re) begin
      bval_q <= bval_mem[addr_q];
      bcol_q <= bcol_mem[addr_q];
    end
  end

  // Dense accumulator row
  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[col_q] <= acc_wd;
    end
    if (acc_re) begin
      acc_rd_q <= acc_mem[col_q];
    end
  end

endmodule

@@ rtl/core/sparse_row_matrix_multiply_unit.sv @@
// Load B entry: row table read, then append and acknowledge; A entry: row table read, then
// a walk over every entry of that B row. Finish: OUT_COLS words; clear B store: row table sweep.
// One command runs at a time; a 2-word queue accepts until full while the back end works.
// The walk takes one B entry at a time: read B entry, multiply, read accumulator, add-and-write.
// After reset a clearing pass over the row table runs with ready low.
// Reset is asynchronous, active low; accumulators reset to zero, B store empties.
module sparse_row_matrix_multiply_unit
  import srmm_pkg::*;
#(
  parameter int unsigned INNER_DIM      = INNER_DIM_DEF,
  parameter int unsigned OUT_COLS       = OUT_COLS_DEF,
  parameter int unsigned B_NNZ_CAPACITY = B_NNZ_CAPACITY_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  srmm_in_if.sink    req_i,
  srmm_out_if.source rsp_o
);

  logic cmd_valid, cmd_pop, busy_init;
  cmd_t cmd;

  srmm_front #(
    .INNER_DIM (INNER_DIM),
    .OUT_COLS  (OUT_COLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .busy_init_i (busy_init),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  srmm_back #(
    .INNER_DIM      (INNER_DIM),
    .OUT_COLS       (OUT_COLS),
    .B_NNZ_CAPACITY (B_NNZ_CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .busy_init_o (busy_init),
    .rsp_o       (rsp_o)
  );

endmodule
